// File: sv/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types, widths, register indexes, reset values and accumulator
// saturation of the radial distortion remap.
// ----------------------------------------------------------------------------
package rdr_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTER_XY = 3'd0,
        REG_INV_CR    = 3'd1,
        REG_COEFF0    = 3'd2,
        REG_COEFF1    = 3'd3,
        REG_COEFF2    = 3'd4,
        REG_COEFF3    = 3'd5,
        REG_COEFF4    = 3'd6,
        REG_COEFF5    = 3'd7
    } cfg_reg_t;

    localparam int NumCoeff  = 6;
    localparam int CoeffW    = 21;
    localparam int InvW      = 25;
    localparam int PixW      = 16;
    localparam int OutW      = 18;
    localparam int DiffW     = 17;
    localparam int SqW       = 34;
    localparam int RootW     = 17;
    localparam int RnW       = 31;
    localparam int AccW      = 32;
    localparam int QuoW      = 33;
    localparam int MagW      = 48;

    localparam logic [31:0]       CenterReset = 32'h0800_0800;
    localparam logic [InvW-1:0]   InvReset    = 25'd16384;
    localparam logic [CoeffW-1:0] Coeff1Reset = 21'd65536;

    localparam logic signed [AccW-1:0] AccMax = 32'sh7FFF_FFFF;
    localparam logic signed [AccW-1:0] AccMin = 32'sh8000_0000;

    function automatic logic signed [AccW-1:0] sat_acc(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return AccMax;
        end else if (v < -64'sd2147483648) begin
            return AccMin;
        end
        return v[AccW-1:0];
    endfunction

endpackage

// File: sv/radial_distortion_remap.sv
// ----------------------------------------------------------------------------
// radial_distortion_remap
// Channel  Dir  Payload
// s_axis   in   tdata[15:0] pixel_x, [31:16] pixel_y
// m_axis   out  tdata[17:0] start_x, [35:18] start_y; tuser saturated
// cfg      in   cfg_index register number, cfg_data value
// One item per clock while the output is not stalled. Register stages: 2 + 17
// (root) + 1 + 2*POLY_ORDER (Horner) + 33 (restoring divider, one quotient
// bit per stage) + 3, i.e. 66 at POLY_ORDER 5. The per-bit divider pipeline
// is the largest part of the depth. The whole pipe advances when the output
// register is empty or taken, so a stall freezes every stage.
// Reset clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module radial_distortion_remap #(
    parameter int POLY_ORDER = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_x, pixel_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // start_x, start_y, zero pad
    output logic        m_axis_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rdr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rdr_pkg::CfgDataW-1:0] cfg_data
);

    localparam int SqSt  = rdr_pkg::RootW;
    localparam int HnSt  = 2 * POLY_ORDER;
    localparam int DvSt  = rdr_pkg::QuoW;
    localparam int Depth = 2 + SqSt + 1 + HnSt + DvSt + 3;

    typedef struct packed {
        logic signed [rdr_pkg::DiffW-1:0] dx;
        logic signed [rdr_pkg::DiffW-1:0] dy;
        logic [rdr_pkg::PixW-1:0]         px;
        logic [rdr_pkg::PixW-1:0]         py;
        logic [rdr_pkg::PixW-1:0]         cx;
        logic [rdr_pkg::PixW-1:0]         cy;
    } geo_t;

    logic [31:0]                      center_reg;
    logic [rdr_pkg::InvW-1:0]         inv_reg;
    logic signed [rdr_pkg::CoeffW-1:0] coeff_reg [rdr_pkg::NumCoeff];
    logic adv;
    logic [Depth-1:0] vld_reg;

    assign cfg_ready     = 1'b1;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= rdr_pkg::CenterReset;
            inv_reg    <= rdr_pkg::InvReset;
            for (int i = 0; i < rdr_pkg::NumCoeff; i++) begin
                coeff_reg[i] <= '0;
            end
            coeff_reg[1] <= rdr_pkg::Coeff1Reset;
        end else if (cfg_valid) begin
            case (cfg_index)
                rdr_pkg::REG_CENTER_XY: center_reg <= cfg_data;
                rdr_pkg::REG_INV_CR:    inv_reg <= cfg_data[rdr_pkg::InvW-1:0];
                rdr_pkg::REG_COEFF0:    coeff_reg[0] <= cfg_data[rdr_pkg::CoeffW-1:0];
                rdr_pkg::REG_COEFF1:    coeff_reg[1] <= cfg_data[rdr_pkg::CoeffW-1:0];
                rdr_pkg::REG_COEFF2:    coeff_reg[2] <= cfg_data[rdr_pkg::CoeffW-1:0];
                rdr_pkg::REG_COEFF3:    coeff_reg[3] <= cfg_data[rdr_pkg::CoeffW-1:0];
                rdr_pkg::REG_COEFF4:    coeff_reg[4] <= cfg_data[rdr_pkg::CoeffW-1:0];
                rdr_pkg::REG_COEFF5:    coeff_reg[5] <= cfg_data[rdr_pkg::CoeffW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[Depth-1];

    // stage 0: differences
    geo_t g0_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            g0_reg.px <= s_axis_tdata[15:0];
            g0_reg.py <= s_axis_tdata[31:16];
            g0_reg.cx <= center_reg[31:16];
            g0_reg.cy <= center_reg[15:0];
            g0_reg.dx <= $signed({1'b0, s_axis_tdata[15:0]})
                       - $signed({1'b0, center_reg[31:16]});
            g0_reg.dy <= $signed({1'b0, s_axis_tdata[31:16]})
                       - $signed({1'b0, center_reg[15:0]});
        end
    end

    // stage 1: squared radius
    geo_t g1_reg;
    logic [rdr_pkg::SqW-1:0] d2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg <= g0_reg;
            d2_reg <= rdr_pkg::SqW'(unsigned'(34'(g0_reg.dx * g0_reg.dx)))
                    + rdr_pkg::SqW'(unsigned'(34'(g0_reg.dy * g0_reg.dy)));
        end
    end

    // square root, one root bit per stage
    geo_t sg_reg [SqSt+1];
    logic [rdr_pkg::SqW+1:0]   rem_reg [SqSt+1];
    logic [rdr_pkg::RootW-1:0] rt_reg  [SqSt+1];
    logic [rdr_pkg::SqW-1:0]   sn_reg  [SqSt+1];
    always_comb begin
        sg_reg[0]  = g1_reg;
        rem_reg[0] = '0;
        rt_reg[0]  = '0;
        sn_reg[0]  = d2_reg;
    end
    for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
        logic [rdr_pkg::SqW+1:0] rs;
        logic [rdr_pkg::SqW+1:0] tr;
        always_comb begin
            rs = {rem_reg[k][rdr_pkg::SqW-1:0], sn_reg[k][rdr_pkg::SqW-1 -: 2]};
            tr = {(rdr_pkg::SqW+2-rdr_pkg::RootW-2)'(0), rt_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sg_reg[k+1] <= sg_reg[k];
                sn_reg[k+1] <= {sn_reg[k][rdr_pkg::SqW-3:0], 2'b00};
                if (rs >= tr) begin
                    rem_reg[k+1] <= rs - tr;
                    rt_reg[k+1]  <= {rt_reg[k][rdr_pkg::RootW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= rs;
                    rt_reg[k+1]  <= {rt_reg[k][rdr_pkg::RootW-2:0], 1'b0};
                end
            end
        end
    end

    // normalized radius
    geo_t g2_reg;
    logic [rdr_pkg::RnW-1:0] rn_reg;
    logic [41:0] rprod;
    assign rprod = 42'(rt_reg[SqSt]) * 42'(inv_reg) + 42'd2048;
    always_ff @(posedge aclk) begin
        if (adv) begin
            g2_reg <= sg_reg[SqSt];
            rn_reg <= rdr_pkg::RnW'(rprod[41:12]);
        end
    end

    // Horner: product stage then add stage per coefficient
    geo_t hg_reg [HnSt+1];
    logic [rdr_pkg::RnW-1:0] hr_reg [HnSt+1];
    logic signed [rdr_pkg::AccW-1:0] ha_reg [HnSt+1];
    always_comb begin
        hg_reg[0] = g2_reg;
        hr_reg[0] = rn_reg;
        ha_reg[0] = rdr_pkg::AccW'(coeff_reg[POLY_ORDER]);
    end
    for (genvar k = 0; k < POLY_ORDER; k++) begin : g_horner
        logic signed [63:0] prod_reg;
        logic signed [63:0] sum;
        assign sum = (prod_reg + 64'sd32768) >>> 16;
        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg        <= 64'(ha_reg[2*k]) * $signed({33'd0, hr_reg[2*k]});
                hg_reg[2*k+1]   <= hg_reg[2*k];
                hr_reg[2*k+1]   <= hr_reg[2*k];
                ha_reg[2*k+1]   <= ha_reg[2*k];
                hg_reg[2*k+2]   <= hg_reg[2*k+1];
                hr_reg[2*k+2]   <= hr_reg[2*k+1];
                ha_reg[2*k+2]   <= rdr_pkg::sat_acc(sum
                    + 64'(coeff_reg[POLY_ORDER-1-k]));
            end
        end
    end

    // ratio: restoring divide of |acc|*2^16 + rn/2 by rn
    geo_t dg_reg [DvSt+1];
    logic [rdr_pkg::RnW-1:0] dd_reg [DvSt+1];
    logic [rdr_pkg::MagW+1:0] dn_reg [DvSt+1];
    logic dr_reg [DvSt+1];
    logic [rdr_pkg::QuoW-1:0] dq_reg [DvSt+1];
    logic ds_reg [DvSt+1];
    logic [rdr_pkg::AccW-1:0] amag;
    assign amag = ha_reg[HnSt][rdr_pkg::AccW-1] ? -ha_reg[HnSt] : ha_reg[HnSt];
    always_comb begin
        dg_reg[0] = hg_reg[HnSt];
        dd_reg[0] = hr_reg[HnSt];
        dn_reg[0] = {amag, 16'd0} + 50'(hr_reg[HnSt] >> 1);
        dr_reg[0] = 1'b0;
        dq_reg[0] = '0;
        ds_reg[0] = ha_reg[HnSt][rdr_pkg::AccW-1];
    end
    for (genvar k = 0; k < DvSt; k++) begin : g_div
        // quotient bit QuoW-1-k; a quotient past QuoW bits saturates.
        localparam int B = DvSt - 1 - k;
        logic [rdr_pkg::MagW+1:0] hi;
        logic ovf;
        assign hi  = dn_reg[k] >> B;
        assign ovf = (k == 0) && ((hi >> 1) >= 50'(dd_reg[k]));
        logic [rdr_pkg::MagW+1:0] sub;
        assign sub = 50'(dd_reg[k]) << B;
        always_ff @(posedge aclk) begin
            if (adv) begin
                dg_reg[k+1] <= dg_reg[k];
                dd_reg[k+1] <= dd_reg[k];
                ds_reg[k+1] <= ds_reg[k];
                dr_reg[k+1] <= dr_reg[k] || ovf;
                if (hi >= 50'(dd_reg[k])) begin
                    dn_reg[k+1] <= dn_reg[k] - sub;
                    dq_reg[k+1] <= dq_reg[k] | (rdr_pkg::QuoW'(1) << B);
                end else begin
                    dn_reg[k+1] <= dn_reg[k];
                    dq_reg[k+1] <= dq_reg[k];
                end
            end
        end
    end

    // quotient bound and sign
    geo_t g3_reg;
    logic signed [rdr_pkg::AccW:0] ratio_reg;
    logic zero_reg;
    logic [rdr_pkg::QuoW:0] qb;
    always_comb begin
        qb = {1'b0, dq_reg[DvSt]};
        if (dr_reg[DvSt] || qb > 34'h0_8000_0000) begin
            qb = 34'h0_8000_0000;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            g3_reg    <= dg_reg[DvSt];
            zero_reg  <= (dd_reg[DvSt] == 0);
            ratio_reg <= ds_reg[DvSt] ? -$signed(qb[rdr_pkg::AccW:0])
                       : (qb > 34'h0_7FFF_FFFF ? 33'sh0_7FFF_FFFF
                                               : $signed(qb[rdr_pkg::AccW:0]));
        end
    end

    // scale offsets
    geo_t g4_reg;
    logic zero4_reg;
    logic signed [63:0] mx_reg, my_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            g4_reg    <= g3_reg;
            zero4_reg <= zero_reg;
            mx_reg    <= 64'(g3_reg.dx) * 64'(ratio_reg);
            my_reg    <= 64'(g3_reg.dy) * 64'(ratio_reg);
        end
    end

    // final add, clamp, zero-radius pass-through and output register
    logic signed [63:0] tx, ty;
    logic sx_hi, sx_lo, sy_hi, sy_lo;
    logic [rdr_pkg::OutW-1:0] ox, oy;
    always_comb begin
        tx = 64'($signed({1'b0, g4_reg.cx})) + ((mx_reg + 64'sd32768) >>> 16);
        ty = 64'($signed({1'b0, g4_reg.cy})) + ((my_reg + 64'sd32768) >>> 16);
        sx_hi = tx > 64'sd131071;
        sx_lo = tx < -64'sd131072;
        sy_hi = ty > 64'sd131071;
        sy_lo = ty < -64'sd131072;
        ox = sx_hi ? 18'h1FFFF : (sx_lo ? 18'h20000 : tx[rdr_pkg::OutW-1:0]);
        oy = sy_hi ? 18'h1FFFF : (sy_lo ? 18'h20000 : ty[rdr_pkg::OutW-1:0]);
    end
    logic [rdr_pkg::OutW-1:0] sxo_reg, syo_reg;
    logic sat_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (zero4_reg) begin
                sxo_reg <= {2'b00, g4_reg.px};
                syo_reg <= {2'b00, g4_reg.py};
                sat_reg <= 1'b0;
            end else begin
                sxo_reg <= ox;
                syo_reg <= oy;
                sat_reg <= sx_hi || sx_lo || sy_hi || sy_lo;
            end
        end
    end
    assign m_axis_tdata = {4'd0, syo_reg, sxo_reg};
    assign m_axis_tuser = sat_reg;

endmodule

// File: sv/rdr_checker.sv
// ----------------------------------------------------------------------------
// rdr_checker
// Port-level checks on the radial distortion remap.
// ----------------------------------------------------------------------------
module rdr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped during stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output free");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
        else $error("pad bits set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");

endmodule

bind radial_distortion_remap rdr_checker u_rdr_checker (.*);

// File: bench/radial_distortion_remap_tb.sv
// ----------------------------------------------------------------------------
// radial_distortion_remap_tb
// Streams film coordinates through the remap under several register
// settings, with bursty input, receiver stalls and one long hold-off. A
// fixed-point model of the remap predicts every result, and the testbench
// checks each result, all fields at once, in order.
// ----------------------------------------------------------------------------
module radial_distortion_remap_tb;

    typedef struct packed {
        logic [15:0] py;
        logic [15:0] px;
    } point_t;

    typedef struct packed {
        logic signed [rdr_pkg::OutW-1:0] sx;
        logic signed [rdr_pkg::OutW-1:0] sy;
        logic                            sat;
    } remap_t;

    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;
    localparam longint OMAX = 64'sd131071;
    localparam longint OMIN = -64'sd131072;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata = '0;   // pixel_x, pixel_y
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [39:0]                  m_axis_tdata;        // start_x, start_y, zero pad
    logic                         m_axis_tuser;        // saturated
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rdr_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [rdr_pkg::CfgDataW-1:0] cfg_data = '0;

    point_t pending_points[$];
    remap_t expected_remaps[$];
    int     mismatches = 0;
    int     cyc = 0;

    logic [31:0]              sh_center = rdr_pkg::CenterReset;
    logic [rdr_pkg::InvW-1:0] sh_inv = rdr_pkg::InvReset;
    longint                   sh_coeff[rdr_pkg::NumCoeff] = '{0, 65536, 0, 0, 0, 0};

    radial_distortion_remap dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint int_sqrt(input longint n);
        longint root, bitv;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic longint rshift_round(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic point_t mk_point(input logic [15:0] x, input logic [15:0] y);
        point_t p;
        p.px = x;
        p.py = y;
        return p;
    endfunction

    function automatic remap_t remap_point(input point_t p);
        longint cx, cy, dx, dy, r, rn, acc, mag, q, ratio, tx, ty, sx, sy;
        remap_t o;
        cx = sh_center[31:16];
        cy = sh_center[15:0];
        dx = longint'(p.px) - cx;
        dy = longint'(p.py) - cy;
        r  = int_sqrt(dx * dx + dy * dy);
        rn = rshift_round(r * longint'(sh_inv), 12);
        if (rn == 0) begin
            o.sx  = p.px;
            o.sy  = p.py;
            o.sat = 1'b0;
            return o;
        end
        acc = sh_coeff[5];
        for (int k = 4; k >= 0; k--)
            acc = clip(rshift_round(acc * rn, 16) + sh_coeff[k], LMIN, LMAX);
        mag = (acc < 0 ? -acc : acc) * 65536;
        q = (mag + (rn >>> 1)) / rn;
        if (q > LMAX + 1) q = LMAX + 1;
        ratio = clip(acc < 0 ? -q : q, LMIN, LMAX);
        tx = cx + rshift_round(dx * ratio, 16);
        ty = cy + rshift_round(dy * ratio, 16);
        sx = clip(tx, OMIN, OMAX);
        sy = clip(ty, OMIN, OMAX);
        o.sx  = sx[rdr_pkg::OutW-1:0];
        o.sy  = sy[rdr_pkg::OutW-1:0];
        o.sat = (sx != tx) || (sy != ty);
        return o;
    endfunction

    // sender: bursts and gaps
    int burst_left = 8;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0 || pending_points.size() == 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_points.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // long hold-off, once, while plenty of items wait
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && cyc >= 50 && pending_points.size() > 100) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // receiver: pattern mode, redrawn per window of the cyc counter
    int rx_mode = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 3) != 0;
                2: m_axis_tready <= $urandom_range(0, 9) < 3;
                default: m_axis_tready <= cyc[2];
            endcase
        end
    end

    // predictor, register shadow and checker
    always @(posedge aclk) begin
        remap_t exp_r, got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (rdr_pkg::cfg_reg_t'(cfg_index))
                    rdr_pkg::REG_CENTER_XY: sh_center <= cfg_data;
                    rdr_pkg::REG_INV_CR:    sh_inv <= cfg_data[rdr_pkg::InvW-1:0];
                    default: sh_coeff[int'(cfg_index) - int'(rdr_pkg::REG_COEFF0)]
                        <= $signed(cfg_data[rdr_pkg::CoeffW-1:0]);
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_remaps.insert(expected_remaps.size(), remap_point(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.sx  = m_axis_tdata[17:0];
                got.sy  = m_axis_tdata[35:18];
                got.sat = m_axis_tuser;
                if (expected_remaps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: exp none got x=%0d y=%0d sat=%0b",
                                 got.sx, got.sy, got.sat);
                end else begin
                    exp_r = expected_remaps.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
                                     exp_r.sx, exp_r.sy, exp_r.sat, got.sx, got.sy, got.sat);
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_points.size() != 0 || s_axis_tvalid
                   || expected_remaps.size() != 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input rdr_pkg::cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] coeff_val(input int mode, input int k);
        case (mode)
            1: return 32'(21'h0FFFFF);
            2: return 32'(21'h100000);
            3: return 32'($urandom);
            default: begin
                if (k == 1) return 32'(65536 + int'($urandom_range(0, 16384)) - 8192);
                return 32'(int'($urandom_range(0, 8192)) - 4096);
            end
        endcase
    endfunction

    task automatic program_phase(input int ph);
        int cm;
        logic [31:0] inv_v;
        cm = (ph == 3) ? 1 : (ph == 4) ? 2 : (ph == 7) ? 3 : 0;
        case (ph)
            1: write_reg(rdr_pkg::REG_CENTER_XY, 32'h0000_0000);
            2: write_reg(rdr_pkg::REG_CENTER_XY, 32'hFFFF_FFFF);
            default: write_reg(rdr_pkg::REG_CENTER_XY, $urandom);
        endcase
        case (ph)
            2: inv_v = 32'h01FF_FFFF;
            5: inv_v = 0;
            6: inv_v = 1;
            7: inv_v = 32'h0100_0000;
            default: inv_v = $urandom_range(1000, 100000);
        endcase
        write_reg(rdr_pkg::REG_INV_CR, inv_v);
        for (int k = 0; k < rdr_pkg::NumCoeff; k++)
            write_reg(rdr_pkg::cfg_reg_t'(rdr_pkg::REG_COEFF0 + k), coeff_val(cm, k));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        point_t p;
        logic [15:0] cx, cy;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_idle();
                program_phase(ph);
                @(posedge aclk);
            end
            cx = sh_center[31:16];
            cy = sh_center[15:0];
            pending_points.insert(pending_points.size(), mk_point(16'h0000, 16'h0000));
            pending_points.insert(pending_points.size(), mk_point(16'hFFFF, 16'hFFFF));
            pending_points.insert(pending_points.size(), mk_point(16'h0000, 16'hFFFF));
            pending_points.insert(pending_points.size(), mk_point(16'hFFFF, 16'h0000));
            pending_points.insert(pending_points.size(), mk_point(cx, cy));
            pending_points.insert(pending_points.size(), mk_point(cx + 16'd1, cy));
            pending_points.insert(pending_points.size(), mk_point(cx, cy - 16'd1));
            for (int i = 0; i < 220; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    p = $urandom;
                end else begin
                    p.px = cx + 16'($urandom_range(0, 64)) - 16'd32;
                    p.py = cy + 16'($urandom_range(0, 64)) - 16'd32;
                end
                pending_points.insert(pending_points.size(), p);
            end
        end
        wait_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
